// ===== sv/plk_pkg.sv =====
// Shared types, codes and the CRC-8 step function for the packet link block.
`default_nettype none
package plk_pkg;

   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_CRC_POLY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RETX_TYPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACK_TYPE  = 2'd2;

   localparam logic [1:0] REQ_LINK_BYTE = 2'd0;
   localparam logic [1:0] REQ_HOST_BYTE = 2'd1;
   localparam logic [1:0] REQ_HOST_POP  = 2'd2;

   localparam logic [1:0] KIND_LINK   = 2'd0;
   localparam logic [1:0] KIND_HOST   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] BYTE_ZERO  = 8'h00;
   localparam logic [7:0] RESET_POLY = 8'h07;
   localparam logic [7:0] RESET_RETX = 8'h02;
   localparam logic [7:0] RESET_ACK  = 8'h01;

   // what one accepted transaction produces
   typedef enum logic [2:0] {
      MODE_STATUS,
      MODE_HOST,
      MODE_CTRL,
      MODE_RESEND,
      MODE_POP
   } plk_mode_type;

   typedef struct packed {
      logic         accept;
      logic         fetch;
      logic         load;
      logic         last;
      plk_mode_type mode;
   } plk_cmd_type;

   typedef struct packed {
      logic         out_free;
      plk_mode_type plan;
   } plk_stat_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== sv/plk_if.sv =====
// Channel interfaces: request, response and register write.
`default_nettype none
interface plk_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] data_byte;
   logic       needs_ack;
   logic       host_last;
   modport source (output valid, req_type, data_byte, needs_ack, host_last, input ready);
   modport sink (input valid, req_type, data_byte, needs_ack, host_last, output ready);
endinterface

interface plk_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] out_byte;
   logic       out_last;
   logic       ack_seen;
   logic       awaiting_ack;
   logic       queue_empty;
   logic       crc_error;
   logic       queue_overflow;
   modport source (output valid, out_kind, out_byte, out_last, ack_seen, awaiting_ack,
                   queue_empty, crc_error, queue_overflow, input ready);
   modport sink (input valid, out_kind, out_byte, out_last, ack_seen, awaiting_ack,
                 queue_empty, crc_error, queue_overflow, output ready);
endinterface

interface plk_csr_if;
   logic                           valid;
   logic                           ready;
   logic [plk_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [7:0]                     wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ===== sv/plk_ctrl.sv =====
// Controller: sequences one transaction's results byte by byte.
`default_nettype none
module plk_ctrl #(
   parameter int PKT_LEN = 19
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  plk_pkg::plk_stat_type  stat,
   output plk_pkg::plk_cmd_type   cmd,
   output logic [$clog2(PKT_LEN)-1:0] idx
);
   localparam int IDX_W = $clog2(PKT_LEN);

   typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_EMIT} state_type;

   state_type             state_ff;
   logic [IDX_W-1:0]      idx_ff;
   plk_pkg::plk_mode_type mode_ff;
   logic                  single;

   always_comb begin
      single      = (mode_ff == plk_pkg::MODE_STATUS) || (mode_ff == plk_pkg::MODE_HOST);
      req_ready   = (state_ff == ST_IDLE);
      cmd.accept  = req_valid && (state_ff == ST_IDLE);
      cmd.fetch   = (state_ff == ST_FETCH);
      cmd.load    = (state_ff == ST_EMIT) && stat.out_free;
      cmd.last    = single || (idx_ff == IDX_W'(PKT_LEN - 1));
      cmd.mode    = mode_ff;
      idx         = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         mode_ff  <= plk_pkg::MODE_STATUS;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.accept) begin
                  mode_ff  <= stat.plan;
                  idx_ff   <= '0;
                  state_ff <= (stat.plan == plk_pkg::MODE_RESEND ||
                               stat.plan == plk_pkg::MODE_POP) ? ST_FETCH : ST_EMIT;
               end
            end
            ST_FETCH: state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (cmd.load) begin
                  if (cmd.last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + IDX_W'(1);
                     state_ff <= (mode_ff == plk_pkg::MODE_CTRL) ? ST_EMIT : ST_FETCH;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_single_goes_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && (stat.plan == plk_pkg::MODE_STATUS || stat.plan == plk_pkg::MODE_HOST)
      |=> state_ff == ST_EMIT) else $error("single result did not go to emit");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> idx_ff <= IDX_W'(PKT_LEN - 1))
      else $error("byte index beyond packet");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.load && cmd.last |=> state_ff == ST_IDLE) else $error("last result did not end");
   a_fetch_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |=> state_ff == ST_EMIT) else $error("fetch not followed by emit");

endmodule
`default_nettype wire

// ===== sv/plk_dp.sv =====
// Datapath: registers, deframer, queue memory, last-sent store and result register.
`default_nettype none
module plk_dp #(
   parameter int DATA_BYTES    = 16,
   parameter int QUEUE_PACKETS = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [1:0]             req_type,
   input  wire  [7:0]             data_byte,
   input  wire                    needs_ack,
   input  wire                    host_last,
   input  wire                    csr_we,
   input  wire  [plk_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [7:0]             csr_wdata,
   input  plk_pkg::plk_cmd_type   cmd,
   input  wire  [$clog2(DATA_BYTES+3)-1:0] idx,
   output plk_pkg::plk_stat_type  stat,
   input  wire                    rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             out_kind,
   output logic [7:0]             out_byte,
   output logic                   out_last,
   output logic                   ack_seen,
   output logic                   awaiting_ack,
   output logic                   queue_empty,
   output logic                   crc_error,
   output logic                   queue_overflow
);
   localparam int PKT_LEN = DATA_BYTES + 3;
   localparam int IDX_W   = $clog2(PKT_LEN);
   localparam int FILL_W  = $clog2(PKT_LEN + 1);
   localparam int CNT_W   = $clog2(DATA_BYTES + 1);
   localparam int PTR_W   = $clog2(QUEUE_PACKETS);
   localparam int QDEPTH  = QUEUE_PACKETS * PKT_LEN;
   localparam int AW      = $clog2(QDEPTH);

   typedef enum logic [1:0] {PH_TYPE, PH_CMD, PH_DATA, PH_CRC} phase_type;

   logic [7:0] poly_ff, retx_ff, ack_ff;
   phase_type  phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] first_ff, first_in;
   logic       ones_ff, ones_in;       // command and data bytes all 0xFF so far
   logic       wait_ff, wait_in;
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in, tail_next;
   logic [AW-1:0]    hbase_ff, hbase_in, tbase_ff, tbase_in, rbase_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic       ackf_ff, ackf_in, crcerr_ff, crcerr_in, ovf_ff, ovf_in;
   logic [7:0] ctype_ff, ctype_in, gcrc_ff, host_ff;
   plk_pkg::plk_mode_type plan;

   logic [7:0]       q_mem [QDEPTH];
   logic [7:0]       q_rd_ff;
   logic             q_we;
   logic [AW-1:0]    q_waddr, q_off;
   logic [7:0]       ls_mem [PKT_LEN];
   logic [PKT_LEN-1:0] ls_valid_ff;
   logic [7:0]       ls_rd_ff, ls_wdata, gen_byte;
   logic             ls_we;
   logic [IDX_W-1:0] ls_waddr;
   logic             rsp_valid_ff, out_free;
   logic             crc_ok;

   assign tail_next = (tail_ff == PTR_W'(QUEUE_PACKETS - 1)) ? '0 : tail_ff + PTR_W'(1);
   assign gen_byte  = (idx == '0) ? ctype_ff :
                      (idx == IDX_W'(PKT_LEN - 1)) ? gcrc_ff : plk_pkg::BYTE_ONES;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign crc_ok    = (data_byte == crc_ff);

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      crc_in    = crc_ff;
      first_in  = first_ff;
      ones_in   = ones_ff;
      wait_in   = wait_ff;
      head_in   = head_ff;
      hbase_in  = hbase_ff;
      tail_in   = tail_ff;
      tbase_in  = tbase_ff;
      fill_in   = fill_ff;
      ackf_in   = 1'b0;
      crcerr_in = 1'b0;
      ovf_in    = 1'b0;
      ctype_in  = ctype_ff;
      plan      = plk_pkg::MODE_STATUS;
      q_we      = 1'b0;
      q_off     = '0;
      case (req_type)
         plk_pkg::REQ_LINK_BYTE: begin
            q_we = 1'b1;
            case (phase_ff)
               PH_TYPE: begin
                  first_in = data_byte;
                  ones_in  = 1'b1;
                  crc_in   = plk_pkg::crc8_byte(plk_pkg::BYTE_ZERO, data_byte, poly_ff);
                  phase_in = PH_CMD;
               end
               PH_CMD: begin
                  q_off    = AW'(1);
                  ones_in  = ones_ff && (data_byte == plk_pkg::BYTE_ONES);
                  crc_in   = plk_pkg::crc8_byte(crc_ff, data_byte, poly_ff);
                  cnt_in   = '0;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  q_off   = AW'(cnt_ff) + AW'(2);
                  ones_in = ones_ff && (data_byte == plk_pkg::BYTE_ONES);
                  crc_in  = plk_pkg::crc8_byte(crc_ff, data_byte, poly_ff);
                  cnt_in  = cnt_ff + CNT_W'(1);
                  if (cnt_ff == CNT_W'(DATA_BYTES - 1)) begin
                     cnt_in   = '0;
                     phase_in = PH_CRC;
                  end
               end
               default: begin
                  q_off    = AW'(PKT_LEN - 1);
                  phase_in = PH_TYPE;
                  if (!crc_ok) begin
                     crcerr_in = 1'b1;
                     ctype_in  = retx_ff;
                     plan      = plk_pkg::MODE_CTRL;
                  end else if (ones_ff && first_ff == retx_ff) begin
                     plan = plk_pkg::MODE_RESEND;
                  end else if (wait_ff) begin
                     if (ones_ff && first_ff == ack_ff) begin
                        wait_in = 1'b0;
                        ackf_in = 1'b1;
                     end
                  end else if (tail_next == head_ff) begin
                     ovf_in = 1'b1;
                  end else begin
                     // packet already sits in the tail slot; commit it
                     tail_in  = tail_next;
                     tbase_in = (tail_next == '0) ? '0 : tbase_ff + AW'(PKT_LEN);
                     ctype_in = ack_ff;
                     plan     = plk_pkg::MODE_CTRL;
                  end
               end
            endcase
         end
         plk_pkg::REQ_HOST_BYTE: begin
            plan = plk_pkg::MODE_HOST;
            if (fill_ff < FILL_W'(PKT_LEN)) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            if (host_last) begin
               fill_in = '0;
               if (needs_ack) begin
                  wait_in = 1'b1;
               end
            end
         end
         plk_pkg::REQ_HOST_POP: begin
            if (head_ff != tail_ff) begin
               plan     = plk_pkg::MODE_POP;
               head_in  = (head_ff == PTR_W'(QUEUE_PACKETS - 1)) ? '0 : head_ff + PTR_W'(1);
               hbase_in = (head_in == '0) ? '0 : hbase_ff + AW'(PKT_LEN);
            end
         end
         default: plan = plk_pkg::MODE_STATUS;
      endcase
      q_waddr = tbase_ff + q_off;
   end

   assign stat.out_free = out_free;
   assign stat.plan     = plan;

   // last-sent store write port: host bytes at accept, control bytes as sent
   always_comb begin
      ls_we    = 1'b0;
      ls_waddr = idx;
      ls_wdata = gen_byte;
      if (cmd.accept && req_type == plk_pkg::REQ_HOST_BYTE && fill_ff < FILL_W'(PKT_LEN)) begin
         ls_we    = 1'b1;
         ls_waddr = fill_ff[IDX_W-1:0];
         ls_wdata = data_byte;
      end else if (cmd.load && cmd.mode == plk_pkg::MODE_CTRL) begin
         ls_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && q_we) begin
         q_mem[q_waddr] <= data_byte;
      end
      if (cmd.fetch) begin
         q_rd_ff <= q_mem[rbase_ff + AW'(idx)];
      end
   end

   always_ff @(posedge clock) begin
      if (ls_we) begin
         ls_mem[ls_waddr] <= ls_wdata;
      end
      if (cmd.fetch) begin
         ls_rd_ff <= ls_valid_ff[idx] ? ls_mem[idx] : plk_pkg::BYTE_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff      <= plk_pkg::RESET_POLY;
         retx_ff      <= plk_pkg::RESET_RETX;
         ack_ff       <= plk_pkg::RESET_ACK;
         phase_ff     <= PH_TYPE;
         cnt_ff       <= '0;
         crc_ff       <= '0;
         wait_ff      <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         hbase_ff     <= '0;
         tbase_ff     <= '0;
         fill_ff      <= '0;
         ackf_ff      <= 1'b0;
         crcerr_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         ls_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               plk_pkg::REG_CRC_POLY:  poly_ff <= csr_wdata;
               plk_pkg::REG_RETX_TYPE: retx_ff <= csr_wdata;
               plk_pkg::REG_ACK_TYPE:  ack_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.accept) begin
            phase_ff  <= phase_in;
            cnt_ff    <= cnt_in;
            crc_ff    <= crc_in;
            wait_ff   <= wait_in;
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            hbase_ff  <= hbase_in;
            tbase_ff  <= tbase_in;
            fill_ff   <= fill_in;
            ackf_ff   <= ackf_in;
            crcerr_ff <= crcerr_in;
            ovf_ff    <= ovf_in;
         end
         if (ls_we) begin
            ls_valid_ff[ls_waddr] <= 1'b1;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers; status travels with each byte so a stalled result keeps it
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         first_ff <= first_in;
         ones_ff  <= ones_in;
         ctype_ff <= ctype_in;
         host_ff  <= data_byte;
         rbase_ff <= hbase_ff;
         gcrc_ff  <= plk_pkg::BYTE_ZERO;
      end else if (cmd.load && cmd.mode == plk_pkg::MODE_CTRL) begin
         gcrc_ff <= plk_pkg::crc8_byte(gcrc_ff, gen_byte, poly_ff);
      end
      if (cmd.load) begin
         out_last       <= cmd.last;
         ack_seen       <= ackf_ff;
         awaiting_ack   <= wait_ff;
         queue_empty    <= (head_ff == tail_ff);
         crc_error      <= crcerr_ff;
         queue_overflow <= ovf_ff;
         case (cmd.mode)
            plk_pkg::MODE_HOST: begin
               out_kind <= plk_pkg::KIND_LINK;
               out_byte <= host_ff;
            end
            plk_pkg::MODE_CTRL: begin
               out_kind <= plk_pkg::KIND_LINK;
               out_byte <= gen_byte;
            end
            plk_pkg::MODE_RESEND: begin
               out_kind <= plk_pkg::KIND_LINK;
               out_byte <= ls_rd_ff;
            end
            plk_pkg::MODE_POP: begin
               out_kind <= plk_pkg::KIND_HOST;
               out_byte <= q_rd_ff;
            end
            default: begin
               out_kind <= plk_pkg::KIND_STATUS;
               out_byte <= plk_pkg::BYTE_ZERO;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== sv/packet_link_ack_retransmit.sv =====
// Packet link deframer with CRC-8 check, acknowledgement, retransmit and receive queue.
// Usage:
//   req_if  carries one transaction per item: a received link byte, a host transmit
//           byte (with host_last and needs_ack) or a host pop of one queued packet.
//   rsp_if  returns the results of that item, one byte per transaction, out_last on
//           the final one; every result of an item carries the same status bits.
//   csr_if  writes crc_poly, retx_type_code and ack_type_code; take writes only
//           while no item is in flight.
// Sequencing: a single-result item goes from acceptance straight to the emit state,
// which loads the output register once it is free. A sent control packet (ack or
// retransmit request) streams one byte a cycle while the receiver takes them,
// DATA_BYTES+3 bytes. A resend or a pop reads a registered memory port per byte,
// so a fetch state comes before each byte. The next item is accepted once the last
// result sits in the output register.
// Reset clears parser, pointers, wait flag and the last-sent store (reads as zero);
// the queue memory needs no clearing. If the receiver stalls, the output register
// holds its transaction and the sequencer waits without losing a byte.
`default_nettype none
module packet_link_ack_retransmit #(
   parameter int DATA_BYTES    = 16,
   parameter int QUEUE_PACKETS = 8
) (
   input wire         clock,
   input wire         reset,
   plk_req_if.sink    req_if,
   plk_rsp_if.source  rsp_if,
   plk_csr_if.sink    csr_if
);
   localparam int PKT_LEN = DATA_BYTES + 3;

   plk_pkg::plk_cmd_type  cmd;
   plk_pkg::plk_stat_type stat;
   logic [$clog2(PKT_LEN)-1:0] idx;

   assign csr_if.ready = 1'b1;

   plk_ctrl #(.PKT_LEN(PKT_LEN)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd),
      .idx       (idx)
   );

   plk_dp #(.DATA_BYTES(DATA_BYTES), .QUEUE_PACKETS(QUEUE_PACKETS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_if.req_type),
      .data_byte      (req_if.data_byte),
      .needs_ack      (req_if.needs_ack),
      .host_last      (req_if.host_last),
      .csr_we         (csr_if.valid),
      .csr_index      (csr_if.reg_index),
      .csr_wdata      (csr_if.wdata),
      .cmd            (cmd),
      .idx            (idx),
      .stat           (stat),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .out_kind       (rsp_if.out_kind),
      .out_byte       (rsp_if.out_byte),
      .out_last       (rsp_if.out_last),
      .ack_seen       (rsp_if.ack_seen),
      .awaiting_ack   (rsp_if.awaiting_ack),
      .queue_empty    (rsp_if.queue_empty),
      .crc_error      (rsp_if.crc_error),
      .queue_overflow (rsp_if.queue_overflow)
   );

endmodule
`default_nettype wire
